[rtl/tcm_pkg.sv]
// Shared widths and constants for the touch calibration mapper.
package tcm_pkg;

  localparam int RAW_W  = 12;
  localparam int SIZE_W = 11;
  localparam int PIX_W  = 12;
  localparam int NUM_W  = 23;
  localparam int DEN_W  = 12;
  localparam int CNT_W  = $clog2(NUM_W + 1);

  localparam logic [2:0] PHASE_MAP = 3'd4;

  localparam logic signed [PIX_W-1:0] PIX_MAX = 12'sh7FF;
  localparam logic signed [PIX_W-1:0] PIX_MIN = 12'sh800;

endpackage

[rtl/tcm_divider.sv]
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
module tcm_divider import tcm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output logic             done
);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             fits;

  assign shifted  = {rem, quo[NUM_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, divisor};
  assign fits     = ~diff[DEN_W+1];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        quo <= dividend;
        cnt <= CNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        quo  <= {quo[NUM_W-2:0], fits};
        rem  <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        done <= (cnt == CNT_W'(1));
      end
    end
  end

endmodule

[rtl/touch_calibration_mapper.sv]
// Four-touch calibration and raw-to-screen coordinate mapper, top level.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   input    | in_valid, in_ready  | raw_x, raw_y
//   output   | out_valid, out_ready| stage, screen_x, screen_y, bad_span, clipped
//
// Calibration transactions go from idle straight to the done state. Mapped
// transactions run per axis a multiply step, a divider load, the divider
// iterations and a writeback; an axis with zero span skips the divide.
// The serial divider is shared by both axes; in_ready is high only when idle.
// Reset clears phase, bounds and handshake state. A held result stalls the
// final writeback until out_ready.
module touch_calibration_mapper import tcm_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240,
  parameter int RAW_BITS      = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [RAW_W-1:0]        raw_x,
  input  logic [RAW_W-1:0]        raw_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              stage,
  output logic signed [PIX_W-1:0] screen_x,
  output logic signed [PIX_W-1:0] screen_y,
  output logic                    bad_span,
  output logic                    clipped
);

  localparam int MASK_BITS = (RAW_BITS < RAW_W) ? RAW_BITS : RAW_W;
  localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((64'd1 << MASK_BITS) - 64'd1);
  localparam logic [SIZE_W-1:0] SIZE_X = SIZE_W'(SCREEN_WIDTH);
  localparam logic [SIZE_W-1:0] SIZE_Y = SIZE_W'(SCREEN_HEIGHT);
  localparam logic [NUM_W-1:0]  POS_LIM = NUM_W'(2047);
  localparam logic [NUM_W-1:0]  NEG_LIM = NUM_W'(2048);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_START, S_DIV, S_DONE} state_t;

  state_t state;
  logic [2:0]       cal_phase;
  logic [RAW_W-1:0] x_low, x_high, y_low, y_high;
  logic [RAW_W-1:0] rx, ry;
  logic             axis;
  logic signed [PIX_W-1:0] sx, sy;
  logic             zflag, sflag;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;

  logic [RAW_W-1:0]   raw_sel, lo_sel, hi_sel;
  logic [SIZE_W-1:0]  size_sel;
  logic signed [RAW_W:0] diff, span;
  logic signed [24:0] prod;
  logic [NUM_W-1:0]   num_mag;
  logic [DEN_W-1:0]   span_mag;
  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_quo;
  logic               clip;
  logic signed [PIX_W-1:0] pix;

  assign in_ready  = (state == S_IDLE);
  assign div_start = (state == S_START);

  assign raw_sel  = axis ? ry : rx;
  assign lo_sel   = axis ? y_low : x_low;
  assign hi_sel   = axis ? y_high : x_high;
  assign size_sel = axis ? SIZE_Y : SIZE_X;
  assign diff     = $signed({1'b0, raw_sel}) - $signed({1'b0, lo_sel});
  assign span     = $signed({1'b0, hi_sel}) - $signed({1'b0, lo_sel});
  assign prod     = 25'(diff) * 25'($signed({1'b0, size_sel}));
  assign num_mag  = prod[24] ? NUM_W'(-prod) : prod[NUM_W-1:0];
  assign span_mag = span[RAW_W] ? DEN_W'(-span) : span[DEN_W-1:0];

  always_comb begin
    if (neg_r) begin
      clip = (div_quo > NEG_LIM);
      pix  = clip ? PIX_MIN : PIX_W'(NUM_W'(0) - div_quo);
    end else begin
      clip = (div_quo > POS_LIM);
      pix  = clip ? PIX_MAX : div_quo[PIX_W-1:0];
    end
  end

  tcm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (den_r),
    .quotient (div_quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cal_phase <= '0;
      x_low     <= '0;
      x_high    <= '0;
      y_low     <= '0;
      y_high    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rx    <= raw_x & RAW_MASK;
            ry    <= raw_y & RAW_MASK;
            axis  <= 1'b0;
            sx    <= '0;
            sy    <= '0;
            zflag <= 1'b0;
            sflag <= 1'b0;
            state <= (cal_phase == PHASE_MAP) ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          if (span == '0) begin
            zflag <= 1'b1;
            axis  <= 1'b1;
            state <= axis ? S_DONE : S_MUL;
          end else begin
            num_r <= num_mag;
            den_r <= span_mag;
            neg_r <= prod[24] ^ span[RAW_W];
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (axis) sy <= pix;
            else sx <= pix;
            sflag <= sflag | clip;
            axis  <= 1'b1;
            state <= axis ? S_DONE : S_MUL;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            stage     <= cal_phase;
            screen_x  <= sx;
            screen_y  <= sy;
            bad_span  <= zflag;
            clipped   <= sflag;
            case (cal_phase)
              3'd0: begin
                x_low <= rx;
                y_low <= ry;
              end
              3'd1: begin
                x_high <= rx;
                y_high <= ry;
              end
              3'd2: begin
                x_low  <= RAW_W'(({1'b0, x_low} + {1'b0, rx}) >> 1);
                y_high <= RAW_W'(({1'b0, y_high} + {1'b0, ry}) >> 1);
              end
              3'd3: begin
                x_high <= RAW_W'(({1'b0, x_high} + {1'b0, rx}) >> 1);
                y_low  <= RAW_W'(({1'b0, y_low} + {1'b0, ry}) >> 1);
              end
              default: ;
            endcase
            if (cal_phase != PHASE_MAP) cal_phase <= cal_phase + 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after an input transaction");

  a_phase_sticks: assert property (@(posedge clk) disable iff (rst)
    (cal_phase == PHASE_MAP) |=> (cal_phase == PHASE_MAP))
    else $error("calibration phase left mapping mode");

  a_cal_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stage != PHASE_MAP) |->
      (screen_x == '0 && screen_y == '0 && !bad_span && !clipped))
    else $error("calibration result carries nonzero mapping fields");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

endmodule
